[src/crdf_pkg.sv]
// Shared types and constants for the climate report deadband filter.
package crdf_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    REG_REPORT_INTERVAL = 2'd0,
    REG_TEMP_DEADBAND   = 2'd1,
    REG_TEMP_OFFSET     = 2'd2
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [31:0] REPORT_INTERVAL_RST = 32'd10000;
  localparam logic [7:0]  TEMP_DEADBAND_RST   = 8'd5;
  localparam logic [7:0]  TEMP_OFFSET_RST     = 8'd26;

  // Humidity jump, in tenths of a percent, beyond which a change is reported at once
  localparam logic [10:0] HUMIDITY_STEP = 11'd10;

  // Valid ranges of the raw sensor values
  localparam logic signed [11:0] TEMP_MIN_RAW = -12'sd1000;
  localparam logic signed [11:0] TEMP_MAX_RAW = 12'sd1400;
  localparam logic signed [10:0] HUM_MIN_RAW  = 11'sd0;
  localparam logic signed [10:0] HUM_MAX_RAW  = 11'sd1000;

  typedef struct packed {
    logic [31:0] report_interval_ms;
    logic [7:0]  temp_deadband;
    logic [7:0]  temp_offset;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               force_req;
    logic               read_ok;
    logic signed [11:0] raw_temp;
    logic signed [10:0] raw_humidity;
  } item_t;

  typedef struct packed {
    logic [31:0]        last_handled_ms;
    logic signed [11:0] reported_temp;
    logic [9:0]         reported_humidity;
    logic [9:0]         candidate_humidity;
    logic signed [11:0] exact_temp;
    logic [9:0]         exact_humidity;
  } state_t;

  // Flags of one result word; the values come from the state
  typedef struct packed {
    logic handled;
    logic read_error;
    logic temp_report;
    logic humidity_report;
  } flags_t;

endpackage

[src/crdf_in_if.sv]
// Input sample channel of the climate report deadband filter.
interface crdf_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               force_req;
  logic               read_ok;
  logic signed [11:0] raw_temp;
  logic signed [10:0] raw_humidity;

  modport source (output valid, now_ms, force_req, read_ok, raw_temp, raw_humidity,
                  input ready);
  modport sink (input valid, now_ms, force_req, read_ok, raw_temp, raw_humidity,
                output ready);
endinterface

[src/crdf_out_if.sv]
// Result channel of the climate report deadband filter.
interface crdf_out_if;
  logic               valid;
  logic               ready;
  logic               handled;
  logic               read_error;
  logic signed [12:0] exact_temp;
  logic [9:0]         exact_humidity;
  logic               temp_report;
  logic signed [12:0] reported_temp_value;
  logic               humidity_report;
  logic [9:0]         reported_humidity_value;

  modport source (output valid, handled, read_error, exact_temp, exact_humidity,
                  temp_report, reported_temp_value, humidity_report,
                  reported_humidity_value, input ready);
  modport sink (input valid, handled, read_error, exact_temp, exact_humidity,
                temp_report, reported_temp_value, humidity_report,
                reported_humidity_value, output ready);
endinterface

[src/crdf_cfg_if.sv]
// Configuration write channel of the climate report deadband filter.
interface crdf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/crdf_cfg_regs.sv]
// Configuration register file of the climate report deadband filter.
module crdf_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  crdf_cfg_if.sink        cfg_ch,
  output crdf_pkg::cfg_t  cfg
);

  crdf_pkg::cfg_t cfg_r;
  crdf_pkg::cfg_t cfg_nxt;

  // Writes are always taken; an unknown index changes nothing.
  assign cfg_ch.ready = 1'b1;

  // Decode the register index and merge the written word.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        crdf_pkg::REG_REPORT_INTERVAL: cfg_nxt.report_interval_ms = cfg_ch.data;
        crdf_pkg::REG_TEMP_DEADBAND:   cfg_nxt.temp_deadband = cfg_ch.data[7:0];
        crdf_pkg::REG_TEMP_OFFSET:     cfg_nxt.temp_offset = cfg_ch.data[7:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.report_interval_ms <= crdf_pkg::REPORT_INTERVAL_RST;
      cfg_r.temp_deadband      <= crdf_pkg::TEMP_DEADBAND_RST;
      cfg_r.temp_offset        <= crdf_pkg::TEMP_OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/crdf_decide.sv]
// Per-sample decision logic: due test, range check, deadband and humidity rules.
module crdf_decide #(
  parameter logic [10:0] HUMIDITY_STEP = crdf_pkg::HUMIDITY_STEP
) (
  input  crdf_pkg::cfg_t   cfg,
  input  crdf_pkg::item_t  item,
  input  crdf_pkg::state_t state,
  output crdf_pkg::state_t state_nxt,
  output crdf_pkg::flags_t flags
);

  logic [31:0]        elapsed;
  logic               due;
  logic               in_range;
  logic signed [12:0] temp_corr;
  logic signed [12:0] temp_diff;
  logic [12:0]        temp_dist;
  logic               temp_move;
  logic [9:0]         hum;
  logic signed [10:0] hum_diff;
  logic [10:0]        hum_dist;
  logic               hum_jump;
  logic               hum_is_cand;

  // Wrapping time since the last handled sample.
  assign elapsed = item.now_ms - state.last_handled_ms;
  assign due     = item.force_req || (elapsed >= cfg.report_interval_ms);

  // Range check on the raw values, before the offset.
  assign in_range = item.read_ok &&
                    (item.raw_humidity >= crdf_pkg::HUM_MIN_RAW) &&
                    (item.raw_humidity <= crdf_pkg::HUM_MAX_RAW) &&
                    (item.raw_temp >= crdf_pkg::TEMP_MIN_RAW) &&
                    (item.raw_temp <= crdf_pkg::TEMP_MAX_RAW);

  // Offset-corrected temperature and its distance from the last report.
  assign temp_corr = {item.raw_temp[11], item.raw_temp} - $signed({5'd0, cfg.temp_offset});
  assign temp_diff = {state.reported_temp[11], state.reported_temp} - temp_corr;
  assign temp_dist = temp_diff[12] ? 13'(-temp_diff) : 13'(temp_diff);
  assign temp_move = temp_dist >= {5'd0, cfg.temp_deadband};

  // Humidity distance from the last report; a valid reading fits in 10 bits.
  assign hum         = item.raw_humidity[9:0];
  assign hum_diff    = $signed({1'b0, state.reported_humidity}) - $signed({1'b0, hum});
  assign hum_dist    = hum_diff[10] ? 11'(-hum_diff) : 11'(hum_diff);
  assign hum_jump    = hum_dist > HUMIDITY_STEP;
  assign hum_is_cand = hum == state.candidate_humidity;

  // Next state and result flags.
  always_comb begin
    state_nxt = state;
    flags     = '0;
    if (due) begin
      flags.handled             = 1'b1;
      state_nxt.last_handled_ms = item.now_ms;
      if (!in_range) begin
        flags.read_error = 1'b1;
      end else begin
        state_nxt.exact_temp     = temp_corr[11:0];
        state_nxt.exact_humidity = hum;
        if (temp_move) begin
          state_nxt.reported_temp = temp_corr[11:0];
          flags.temp_report       = 1'b1;
        end
        if (!hum_is_cand && !hum_jump) begin
          state_nxt.candidate_humidity = hum;
        end else if ((hum_is_cand && (state.reported_humidity != hum)) || hum_jump) begin
          state_nxt.reported_humidity = hum;
          flags.humidity_report       = 1'b1;
        end
      end
    end
  end

endmodule

[src/climate_report_deadband_filter.sv]
// Top level of the climate report deadband filter: input register, state and result register.
// Usage: one sample word is taken per cycle while the result side does not stall, and each
// taken word gives exactly one result word. A sample passes from the input register
// through the due, range, deadband and humidity decision into the result register, and the
// filter state is updated together with it, so each sample sees everything left by the one
// before it. The input register lets one more sample in while a finished result waits to be
// taken. Configuration writes are taken at once and should be issued only while no sample is
// in flight. HUMIDITY_STEP sets the humidity jump, in tenths of a percent, beyond which a
// change is reported at once.
module climate_report_deadband_filter #(
  parameter logic [10:0] HUMIDITY_STEP = crdf_pkg::HUMIDITY_STEP
) (
  input  logic       clk,
  input  logic       rst_n,
  crdf_in_if.sink    in_ch,
  crdf_out_if.source out_ch,
  crdf_cfg_if.sink   cfg_ch
);

  crdf_pkg::cfg_t   cfg;
  crdf_pkg::item_t  in_item_r;
  logic             in_vld_r;
  logic             in_vld_nxt;
  crdf_pkg::state_t state_r;
  crdf_pkg::state_t state_nxt;
  crdf_pkg::flags_t flags_nxt;
  crdf_pkg::flags_t out_flags_r;
  crdf_pkg::state_t out_state_r;
  logic             out_vld_r;
  logic             out_vld_nxt;
  logic             in_take;
  logic             advance;

  crdf_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  crdf_decide #(
    .HUMIDITY_STEP (HUMIDITY_STEP)
  ) u_decide (
    .cfg       (cfg),
    .item      (in_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .flags     (flags_nxt)
  );

  // A word moves to the result register when that register is empty or being emptied.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Valid bits of the two registers.
  always_comb begin
    in_vld_nxt  = in_take || (in_vld_r && !advance);
    out_vld_nxt = advance || (out_vld_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.now_ms       <= in_ch.now_ms;
      in_item_r.force_req    <= in_ch.force_req;
      in_item_r.read_ok      <= in_ch.read_ok;
      in_item_r.raw_temp     <= in_ch.raw_temp;
      in_item_r.raw_humidity <= in_ch.raw_humidity;
    end
    if (advance) begin
      out_flags_r <= flags_nxt;
      out_state_r <= state_nxt;
    end
  end

  // Result word.
  assign out_ch.valid                   = out_vld_r;
  assign out_ch.handled                 = out_flags_r.handled;
  assign out_ch.read_error              = out_flags_r.read_error;
  assign out_ch.temp_report             = out_flags_r.temp_report;
  assign out_ch.humidity_report         = out_flags_r.humidity_report;
  assign out_ch.exact_temp              = {out_state_r.exact_temp[11], out_state_r.exact_temp};
  assign out_ch.exact_humidity          = out_state_r.exact_humidity;
  assign out_ch.reported_temp_value     = {out_state_r.reported_temp[11],
                                           out_state_r.reported_temp};
  assign out_ch.reported_humidity_value = out_state_r.reported_humidity;

endmodule

[src/crdf_checker.sv]
// Port-level checks of the climate report deadband filter, bound to the top level.
module crdf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               handled,
  input logic               read_error,
  input logic               temp_report,
  input logic               humidity_report,
  input logic signed [12:0] exact_temp,
  input logic signed [12:0] reported_temp_value,
  input logic [9:0]         exact_humidity,
  input logic [9:0]         reported_humidity_value
);

  // A pending result word stays until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // Nothing leaves right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Errors and reports only come from handled samples, and an error reports nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (read_error || temp_report || humidity_report) |->
      handled && !(read_error && (temp_report || humidity_report)))
    else $error("flag set on a sample that was not handled, or a report on an error");

  // A new report carries the value just measured.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (temp_report || humidity_report) |->
      (!temp_report || (reported_temp_value == exact_temp)) &&
      (!humidity_report || (reported_humidity_value == exact_humidity)))
    else $error("reported value differs from the measured value");

endmodule

bind climate_report_deadband_filter crdf_checker u_crdf_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_ch.valid),
  .out_ready               (out_ch.ready),
  .handled                 (out_ch.handled),
  .read_error              (out_ch.read_error),
  .temp_report             (out_ch.temp_report),
  .humidity_report         (out_ch.humidity_report),
  .exact_temp              (out_ch.exact_temp),
  .reported_temp_value     (out_ch.reported_temp_value),
  .exact_humidity          (out_ch.exact_humidity),
  .reported_humidity_value (out_ch.reported_humidity_value)
);

[tb/climate_report_deadband_filter_test.sv]
// Self-checking testbench of the climate report deadband filter, with its own prediction.
`timescale 1ns / 1ps

module climate_report_deadband_filter_test;

  // Register index past the end of the list; a write to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One expected or observed result word.
  typedef struct packed {
    logic               handled;
    logic               read_error;
    logic signed [12:0] exact_temp;
    logic [9:0]         exact_humidity;
    logic               temp_report;
    logic signed [12:0] reported_temp_value;
    logic               humidity_report;
    logic [9:0]         reported_humidity_value;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crdf_in_if  in_ch();
  crdf_out_if out_ch();
  crdf_cfg_if cfg_ch();

  climate_report_deadband_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted filter state and register settings.
  crdf_pkg::cfg_t    settings;
  crdf_pkg::state_t  climate;

  crdf_pkg::item_t words_to_send[$];
  report_t awaited_reports[$];
  int      words_offered;
  int      words_taken;
  int      reports_taken;
  int      reports_seen;
  int      mismatches;
  int unsigned send_gap;
  int unsigned take_gap;
  bit      no_gaps;

  // Stimulus generator: its own view of the last handled time and the walking values.
  logic [31:0] gen_last;
  logic [31:0] gen_now;
  int          walk_temp = 250;
  int          walk_hum = 500;

  function automatic int magnitude(input int v);
    return v < 0 ? -v : v;
  endfunction

  // Work out the result word of one sample and advance the predicted state.
  function automatic report_t deadband_report(input crdf_pkg::item_t s);
    report_t     r;
    logic [31:0] since;
    int          t;
    int          h;
    int          dh;
    r = '0;
    since = s.now_ms - climate.last_handled_ms;
    if (s.force_req || since >= settings.report_interval_ms) begin
      r.handled = 1'b1;
      climate.last_handled_ms = s.now_ms;
      t = $signed(s.raw_temp);
      h = $signed(s.raw_humidity);
      if (!s.read_ok || h < int'(crdf_pkg::HUM_MIN_RAW) || h > int'(crdf_pkg::HUM_MAX_RAW) ||
          t < int'(crdf_pkg::TEMP_MIN_RAW) || t > int'(crdf_pkg::TEMP_MAX_RAW)) begin
        r.read_error = 1'b1;
      end else begin
        t = t - int'(settings.temp_offset);
        dh = int'(climate.reported_humidity) - h;
        climate.exact_temp = t[11:0];
        climate.exact_humidity = h[9:0];
        if (magnitude($signed(climate.reported_temp) - t) >=
            int'(settings.temp_deadband)) begin
          climate.reported_temp = t[11:0];
          r.temp_report = 1'b1;
        end
        // A small move only becomes the candidate; a repeat of an unreported candidate or a big jump is reported.
        if (h != int'(climate.candidate_humidity) &&
            magnitude(dh) <= int'(crdf_pkg::HUMIDITY_STEP)) begin
          climate.candidate_humidity = h[9:0];
        end else if ((h == int'(climate.candidate_humidity) &&
                      int'(climate.reported_humidity) != h) ||
                     magnitude(dh) > int'(crdf_pkg::HUMIDITY_STEP)) begin
          climate.reported_humidity = h[9:0];
          r.humidity_report = 1'b1;
        end
      end
    end
    r.exact_temp = 13'($signed(climate.exact_temp));
    r.exact_humidity = climate.exact_humidity;
    r.reported_temp_value = 13'($signed(climate.reported_temp));
    r.reported_humidity_value = climate.reported_humidity;
    return r;
  endfunction

  function automatic string describe(input report_t r);
    return $sformatf({"handled=%0b err=%0b temp=%0d hum=%0d ",
                      "t_rep=%0b rep_t=%0d h_rep=%0b rep_h=%0d"},
                     r.handled, r.read_error, $signed(r.exact_temp), r.exact_humidity,
                     r.temp_report, $signed(r.reported_temp_value), r.humidity_report,
                     r.reported_humidity_value);
  endfunction

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic queue_word(input logic [31:0] now, input logic force_it, input logic ok,
                            input int temp, input int hum);
    crdf_pkg::item_t s;
    s.now_ms = now;
    s.force_req = force_it;
    s.read_ok = ok;
    s.raw_temp = temp[11:0];
    s.raw_humidity = hum[10:0];
    words_to_send.push_back(s);
  endtask

  // Mostly well-formed walks in time, temperature and humidity; some words are pure noise.
  task automatic queue_walk(input int count);
    logic [31:0] now;
    logic [31:0] interval;
    logic        force_it;
    logic        ok;
    int          temp;
    int          hum;
    int          db;
    int          sgn;
    interval = settings.report_interval_ms;
    db = int'(settings.temp_deadband);
    for (int n = 0; n < count; n++) begin
      sgn = $urandom_range(0, 1) ? 1 : -1;
      if ($urandom_range(0, 99) < 12) begin
        now = $urandom;
        force_it = 1'($urandom_range(0, 1));
        ok = 1'($urandom_range(0, 1));
        temp = int'($urandom_range(0, 4095)) - 2048;
        hum = int'($urandom_range(0, 2047)) - 1024;
      end else begin
        case ($urandom_range(0, 5))
          0: now = gen_last + interval - 1;
          1: now = gen_last + interval;
          2: now = gen_last + interval + 1;
          3: now = gen_now + $urandom_range(0, 50);
          4: now = gen_now + $urandom_range(0, interval);
          default: now = gen_now + interval + $urandom_range(0, 1000);
        endcase
        force_it = ($urandom_range(0, 4) == 0);
        ok = ($urandom_range(0, 19) != 0);
        case ($urandom_range(0, 5))
          0: temp = walk_temp + sgn * db;
          1: temp = walk_temp + sgn * (db - 1);
          2: temp = walk_temp + sgn * int'($urandom_range(0, 3));
          3: temp = int'($urandom_range(0, 2400)) - 1000;
          4: begin
            case ($urandom_range(0, 3))
              0: temp = int'(crdf_pkg::TEMP_MIN_RAW) - 1;
              1: temp = int'(crdf_pkg::TEMP_MIN_RAW);
              2: temp = int'(crdf_pkg::TEMP_MAX_RAW);
              default: temp = int'(crdf_pkg::TEMP_MAX_RAW) + 1;
            endcase
          end
          default: temp = walk_temp;
        endcase
        case ($urandom_range(0, 7))
          0, 1, 2: hum = walk_hum;
          3: hum = walk_hum + sgn * int'($urandom_range(1, 10));
          4: hum = walk_hum + sgn * int'($urandom_range(11, 40));
          5: hum = int'($urandom_range(0, 1000));
          6: hum = walk_hum + sgn * int'($urandom_range(10, 11));
          default: begin
            case ($urandom_range(0, 3))
              0: hum = int'(crdf_pkg::HUM_MIN_RAW) - 1;
              1: hum = int'(crdf_pkg::HUM_MIN_RAW);
              2: hum = int'(crdf_pkg::HUM_MAX_RAW);
              default: hum = int'(crdf_pkg::HUM_MAX_RAW) + 1;
            endcase
          end
        endcase
        if (temp >= int'(crdf_pkg::TEMP_MIN_RAW) && temp <= int'(crdf_pkg::TEMP_MAX_RAW))
          walk_temp = temp;
        if (hum >= int'(crdf_pkg::HUM_MIN_RAW) && hum <= int'(crdf_pkg::HUM_MAX_RAW))
          walk_hum = hum;
      end
      if (force_it || now - gen_last >= interval) gen_last = now;
      gen_now = now;
      queue_word(now, force_it, ok, temp, hum);
    end
  endtask

  // Write one register and mirror it in the predicted settings.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      crdf_pkg::REG_REPORT_INTERVAL: settings.report_interval_ms = value;
      crdf_pkg::REG_TEMP_DEADBAND:   settings.temp_deadband = value[7:0];
      crdf_pkg::REG_TEMP_OFFSET:     settings.temp_offset = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (words_to_send.size() != 0 || words_offered != words_taken ||
           awaited_reports.size() != 0)
      @(posedge clk);
  endtask

  // Offer the queued sample words, with a random pause after each word taken.
  always @(negedge clk) begin : offer_words
    crdf_pkg::item_t s;
    if (!(in_ch.valid && words_offered != words_taken)) begin
      if (in_ch.valid) send_gap = draw_gap();
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        s = words_to_send.pop_front();
        in_ch.now_ms <= s.now_ms;
        in_ch.force_req <= s.force_req;
        in_ch.read_ok <= s.read_ok;
        in_ch.raw_temp <= s.raw_temp;
        in_ch.raw_humidity <= s.raw_humidity;
        in_ch.valid <= 1'b1;
        words_offered++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side for a random pause after each result word taken.
  always @(negedge clk) begin
    if (out_ch.ready && reports_taken != reports_seen) take_gap = draw_gap();
    reports_seen = reports_taken;
    if (take_gap > 0) begin
      take_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Predict on every word taken in, and check every result word taken out.
  always @(posedge clk) begin : watch_ports
    crdf_pkg::item_t s;
    report_t got;
    report_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        s = {in_ch.now_ms, in_ch.force_req, in_ch.read_ok, in_ch.raw_temp, in_ch.raw_humidity};
        awaited_reports.push_back(deadband_report(s));
        words_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.handled, out_ch.read_error, out_ch.exact_temp, out_ch.exact_humidity,
               out_ch.temp_report, out_ch.reported_temp_value, out_ch.humidity_report,
               out_ch.reported_humidity_value};
        reports_taken++;
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with no sample behind it: %s", $time, describe(got));
        end else begin
          want = awaited_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.now_ms = '0;
    in_ch.force_req = 1'b0;
    in_ch.read_ok = 1'b0;
    in_ch.raw_temp = '0;
    in_ch.raw_humidity = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    settings = {crdf_pkg::REPORT_INTERVAL_RST, crdf_pkg::TEMP_DEADBAND_RST,
                crdf_pkg::TEMP_OFFSET_RST};
    climate = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset settings: interval, candidate logic, ranges, wrap.
    queue_word(32'd0, 1'b0, 1'b1, 250, 500);
    queue_word(32'd9999, 1'b0, 1'b1, 250, 500);
    queue_word(32'd10000, 1'b0, 1'b1, 250, 500);
    queue_word(32'd10001, 1'b1, 1'b1, 250, 500);
    queue_word(32'd10002, 1'b1, 1'b1, 254, 500);
    queue_word(32'd10003, 1'b1, 1'b1, 255, 505);
    queue_word(32'd10004, 1'b1, 1'b1, 255, 505);
    queue_word(32'd10005, 1'b1, 1'b1, 255, 515);
    queue_word(32'd10006, 1'b1, 1'b1, 255, 526);
    queue_word(32'd10007, 1'b1, 1'b0, 255, 526);
    queue_word(32'd10008, 1'b1, 1'b1, -1000, 0);
    queue_word(32'd10009, 1'b1, 1'b1, 1400, 1000);
    queue_word(32'd10010, 1'b1, 1'b1, -1001, 500);
    queue_word(32'd10011, 1'b1, 1'b1, 1401, 500);
    queue_word(32'd10012, 1'b1, 1'b1, 250, -1);
    queue_word(32'd10013, 1'b1, 1'b1, 250, 1001);
    queue_word(32'd10014, 1'b1, 1'b1, -2048, -1024);
    queue_word(32'd10015, 1'b1, 1'b1, 2047, 1023);
    queue_word(32'd20014, 1'b0, 1'b1, 300, 990);
    queue_word(32'd20015, 1'b0, 1'b1, 300, 990);
    queue_word(32'hFFFF_FFF0, 1'b1, 1'b1, 300, 990);
    queue_word(32'h0000_26FF, 1'b0, 1'b1, 310, 995);
    queue_word(32'h0000_2700, 1'b0, 1'b1, 310, 995);
    queue_word(32'h0000_2700, 1'b0, 1'b1, 320, 995);

    // Random phases, each under its own settings, extremes among them.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_UNUSED, $urandom);
          write_reg(crdf_pkg::REG_REPORT_INTERVAL, 32'd0);
          write_reg(crdf_pkg::REG_TEMP_DEADBAND, 32'd0);
          write_reg(crdf_pkg::REG_TEMP_OFFSET, 32'd0);
        end
        1: begin
          write_reg(crdf_pkg::REG_REPORT_INTERVAL, 32'hFFFF_FFFF);
          write_reg(crdf_pkg::REG_TEMP_DEADBAND, 32'hFFFF_FFFF);
          write_reg(crdf_pkg::REG_TEMP_OFFSET, 32'd255);
        end
        2: begin
          write_reg(crdf_pkg::REG_REPORT_INTERVAL, 32'd100);
          write_reg(crdf_pkg::REG_TEMP_DEADBAND, 32'd2);
          write_reg(crdf_pkg::REG_TEMP_OFFSET, 32'(crdf_pkg::TEMP_OFFSET_RST));
        end
        3: begin
          write_reg(crdf_pkg::REG_REPORT_INTERVAL, 32'd1000);
          write_reg(crdf_pkg::REG_TEMP_DEADBAND, 32'(crdf_pkg::TEMP_DEADBAND_RST));
          write_reg(crdf_pkg::REG_TEMP_OFFSET, 32'd0);
        end
        4: begin
          write_reg(crdf_pkg::REG_REPORT_INTERVAL, $urandom_range(1, 3000));
          write_reg(crdf_pkg::REG_TEMP_DEADBAND, $urandom_range(0, 20));
          write_reg(crdf_pkg::REG_TEMP_OFFSET, $urandom_range(0, 255));
        end
        default: begin
          write_reg(crdf_pkg::REG_REPORT_INTERVAL, crdf_pkg::REPORT_INTERVAL_RST);
          write_reg(crdf_pkg::REG_TEMP_DEADBAND, 32'(crdf_pkg::TEMP_DEADBAND_RST));
          write_reg(crdf_pkg::REG_TEMP_OFFSET, 32'(crdf_pkg::TEMP_OFFSET_RST));
        end
      endcase
      no_gaps = (p == 0 || p == 3);
      gen_last = climate.last_handled_ms;
      gen_now = gen_last;
      queue_walk(313);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("climate_report_deadband_filter test passed");
    end else begin
      $display("climate_report_deadband_filter test failed");
    end
    $finish;
  end

  // Give up on a run that hangs.
  initial begin
    #500000;
    $display("climate_report_deadband_filter test failed");
    $finish;
  end

endmodule

[filelist.f]
src/crdf_pkg.sv
src/crdf_in_if.sv
src/crdf_out_if.sv
src/crdf_cfg_if.sv
src/crdf_cfg_regs.sv
src/crdf_decide.sv
src/climate_report_deadband_filter.sv
src/crdf_checker.sv
tb/climate_report_deadband_filter_test.sv
